### design/bezier_curve_point_evaluator_macros.svh
// assertion macros for the bezier curve point evaluator
// used by the controller; expects clk_i and rst_ni in scope
`ifndef BEZIER_CURVE_POINT_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_MACROS_SVH

// clocked property, off during reset
`define BCPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication on top of the clocked form
`define BCPE_ASSERT_IMP(lbl, ante, cons, msg) \
  `BCPE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### design/bcpe_pkg.sv
// shared types and constants of the bezier curve point evaluator
// no dependencies
`default_nettype none
package bcpe_pkg;

  // store size limits
  localparam int MAX_POINTS_DEF   = 8;
  localparam int MAX_POINTS_LIMIT = 12;

  // fixed point constants
  localparam logic [16:0] ONE_T   = 17'h1_0000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // binomial coefficients, row n, column i
  localparam logic [8:0] BINOM [0:MAX_POINTS_LIMIT-1][0:MAX_POINTS_LIMIT-1] = '{
    '{9'd1, 9'd0,  9'd0,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd1,  9'd0,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd2,  9'd1,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd3,  9'd3,  9'd1,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd4,  9'd6,  9'd4,   9'd1,   9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd5,  9'd10, 9'd10,  9'd5,   9'd1,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd6,  9'd15, 9'd20,  9'd15,  9'd6,   9'd1,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd7,  9'd21, 9'd35,  9'd35,  9'd21,  9'd7,   9'd1,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd8,  9'd28, 9'd56,  9'd70,  9'd56,  9'd28,  9'd8,   9'd1,  9'd0,  9'd0,  9'd0},
    '{9'd1, 9'd9,  9'd36, 9'd84,  9'd126, 9'd126, 9'd84,  9'd36,  9'd9,  9'd1,  9'd0,  9'd0},
    '{9'd1, 9'd10, 9'd45, 9'd120, 9'd210, 9'd252, 9'd210, 9'd120, 9'd45, 9'd10, 9'd1,  9'd0},
    '{9'd1, 9'd11, 9'd55, 9'd165, 9'd330, 9'd462, 9'd462, 9'd330, 9'd165, 9'd55, 9'd11, 9'd1}
  };

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       start;
    logic       spow_we;
    logic       rd;
    logic       prod;
    logic       wgt;
    logic       acc;
    logic       fin;
    logic [3:0] idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       empty;
    logic       out_busy;
    logic [3:0] last;
  } sts_t;

endpackage
`default_nettype wire

### design/bcpe_req_if.sv
// request channel of the bezier curve point evaluator
// no dependencies
`default_nettype none
interface bcpe_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic        [2:0]  point_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic        [16:0] param_t;

  modport source (output valid, req_type, point_index, coord_x, coord_y, coord_z, param_t,
                  input ready);
  modport sink (input valid, req_type, point_index, coord_x, coord_y, coord_z, param_t,
                output ready);
endinterface
`default_nettype wire

### design/bcpe_res_if.sv
// result channel of the bezier curve point evaluator
// no dependencies
`default_nettype none
interface bcpe_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

### design/bcpe_ctrl.sv
// sequencer of the bezier curve point evaluator
// uses bcpe_pkg and bezier_curve_point_evaluator_macros.svh
`default_nettype none
`include "bezier_curve_point_evaluator_macros.svh"
module bcpe_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_type_i,
  output logic             in_ready_o,
  input  bcpe_pkg::sts_t   sts_i,
  output bcpe_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SPOW = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_PROD = 3'd3;
  localparam logic [2:0] ST_WGT  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_type_i == bcpe_pkg::REQ_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            idx_d   = '0;
            state_d = sts_i.empty ? ST_FIN : ST_SPOW;
          end
        end
      end
      ST_SPOW: begin
        cmd_o.spow_we = 1'b1;
        if (idx_q == sts_i.last) begin
          idx_d   = '0;
          state_d = ST_RD;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_WGT;
      end
      ST_WGT: begin
        cmd_o.wgt = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (idx_q == sts_i.last) begin
          state_d = ST_FIN;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // checks
  `BCPE_ASSERT_IMP(a_fin_free, cmd_o.fin, !sts_i.out_busy, "result written while busy")
  `BCPE_ASSERT(a_eval_run, (accept && in_type_i == bcpe_pkg::REQ_EVAL && !sts_i.empty)
    |=> (state_q == ST_SPOW), "evaluate did not start power pass")
  `BCPE_ASSERT_IMP(a_idx_range, (state_q != ST_IDLE && state_q != ST_FIN),
    idx_q <= sts_i.last, "point index beyond curve degree")

endmodule
`default_nettype wire

### design/bcpe_datapath.sv
// datapath of the bezier curve point evaluator: point store, power memory,
// multipliers, accumulators and result register; uses bcpe_pkg
`default_nettype none
module bcpe_datapath #(
  parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bcpe_pkg::cmd_t      cmd_i,
  output bcpe_pkg::sts_t      sts_o,
  input  wire                 cfg_we_i,
  input  wire          [3:0]  cfg_wdata_i,
  input  wire          [2:0]  point_index_i,
  input  wire signed   [31:0] coord_x_i,
  input  wire signed   [31:0] coord_y_i,
  input  wire signed   [31:0] coord_z_i,
  input  wire          [16:0] param_t_i,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output logic signed  [31:0] pos_x_o,
  output logic signed  [31:0] pos_y_o,
  output logic signed  [31:0] pos_z_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic        [3:0]  pc_q;
  logic        [3:0]  count;
  logic        [3:0]  last;
  logic signed [31:0] store_x [MAX_POINTS];
  logic signed [31:0] store_y [MAX_POINTS];
  logic signed [31:0] store_z [MAX_POINTS];
  logic        [30:0] spow_mem [MAX_POINTS];
  logic        [16:0] t_q, s_q, t_clamp;
  logic        [30:0] tp_q, sprev_q, srd_q, prod_q;
  logic        [31:0] w_q;
  logic signed [63:0] acc_x_q, acc_y_q, acc_z_q;
  logic        [47:0] s_mul, t_mul;
  logic        [30:0] s_next;
  logic        [61:0] ts_mul;
  logic        [39:0] w_mul;
  logic signed [64:0] px, py, pz;
  logic        [3:0]  rd_idx;
  logic      [AW-1:0] ld_idx;
  logic               valid_q;

  // round q17.46 accumulator to q15.16 and saturate
  function automatic logic [31:0] finish(input logic signed [63:0] acc);
    logic        [63:0] u;
    logic signed [34:0] q;
    u = acc + 64'h4000_0000_2000_0000;
    q = $signed({1'b0, u[63:30]}) - 35'sh1_0000_0000;
    if (q > 35'sh0_7FFF_FFFF) begin
      finish = 32'h7FFF_FFFF;
    end else if (q < -35'sh0_8000_0000) begin
      finish = 32'h8000_0000;
    end else begin
      finish = q[31:0];
    end
  endfunction

  // effective count and degree
  assign count = (pc_q > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : pc_q;
  assign last  = count - 4'd1;
  assign sts_o.empty    = (count == 4'd0);
  assign sts_o.last     = last;
  assign sts_o.out_busy = valid_q && !res_ready_i;

  assign t_clamp = (param_t_i > bcpe_pkg::ONE_T) ? bcpe_pkg::ONE_T : param_t_i;

  // arithmetic
  assign s_mul  = 48'(sprev_q) * 48'(s_q) + 48'h8000;
  assign t_mul  = 48'(tp_q) * 48'(t_q) + 48'h8000;
  assign s_next = (cmd_i.idx == 4'd0) ? bcpe_pkg::ONE_Q30 : s_mul[46:16];
  assign ts_mul = 62'(tp_q) * 62'(srd_q) + 62'h2000_0000;
  assign w_mul  = 40'(bcpe_pkg::BINOM[last][cmd_i.idx]) * 40'(prod_q);
  assign px     = $signed({1'b0, w_q}) * store_x[cmd_i.idx[AW-1:0]];
  assign py     = $signed({1'b0, w_q}) * store_y[cmd_i.idx[AW-1:0]];
  assign pz     = $signed({1'b0, w_q}) * store_z[cmd_i.idx[AW-1:0]];
  assign rd_idx = last - cmd_i.idx;
  assign ld_idx = AW'(point_index_i);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 4'd4;
    end else if (cfg_we_i) begin
      pc_q <= cfg_wdata_i;
    end
  end

  // point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(point_index_i) < MAX_POINTS)) begin
      store_x[ld_idx] <= coord_x_i;
      store_y[ld_idx] <= coord_y_i;
      store_z[ld_idx] <= coord_z_i;
    end
  end

  // power memory of (1-t)
  always_ff @(posedge clk_i) begin
    if (cmd_i.spow_we) begin
      spow_mem[cmd_i.idx[AW-1:0]] <= s_next;
    end
    if (cmd_i.rd) begin
      srd_q <= spow_mem[rd_idx[AW-1:0]];
    end
  end

  // evaluation pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q     <= t_clamp;
      s_q     <= bcpe_pkg::ONE_T - t_clamp;
      tp_q    <= bcpe_pkg::ONE_Q30;
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end
    if (cmd_i.spow_we) begin
      sprev_q <= s_next;
    end
    if (cmd_i.prod) begin
      prod_q <= ts_mul[60:30];
    end
    if (cmd_i.wgt) begin
      w_q <= w_mul[31:0];
    end
    if (cmd_i.acc) begin
      acc_x_q <= acc_x_q + px[63:0];
      acc_y_q <= acc_y_q + py[63:0];
      acc_z_q <= acc_z_q + pz[63:0];
      tp_q    <= t_mul[46:16];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      pos_x_o <= finish(acc_x_q);
      pos_y_o <= finish(acc_y_q);
      pos_z_o <= finish(acc_z_q);
    end
  end

  assign res_valid_o = valid_q;

endmodule
`default_nettype wire

### design/bezier_curve_point_evaluator.sv
// bezier curve point evaluator: loads can follow back to back;
// an evaluate with c points (count clamped to the store) gives its result after the (1-t)
// power pass and four steps per point (read, product, weight, accumulate) through the
// shared weight multipliers; the next request is taken in the cycle after the result is
// written, later while an earlier result is stalled.
// reset sets point_count to 4 and clears control; point store is undefined until written
`default_nettype none
module bezier_curve_point_evaluator #(
  parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bcpe_req_if.sink   req,
  bcpe_res_if.source res,
  input  wire        cfg_we_i,
  input  wire [3:0]  cfg_wdata_i
);

  bcpe_pkg::cmd_t cmd;
  bcpe_pkg::sts_t sts;
  logic           in_ready;

  assign req.ready = in_ready;

  // sequencer
  bcpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_type_i  (req.req_type),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  bcpe_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_index_i (req.point_index),
    .coord_x_i     (req.coord_x),
    .coord_y_i     (req.coord_y),
    .coord_z_i     (req.coord_z),
    .param_t_i     (req.param_t),
    .res_valid_o   (res.valid),
    .res_ready_i   (res.ready),
    .pos_x_o       (res.pos_x),
    .pos_y_o       (res.pos_y),
    .pos_z_o       (res.pos_z)
  );

endmodule
`default_nettype wire
